// File: sv/ptm_pkg.sv
package ptm_pkg;

   localparam int TABLE_DEPTH_DEF  = 64;
   localparam int SOURCE_COUNT_DEF = 256;

   localparam int SOURCE_W  = 8;
   localparam int TAG_W     = 32;
   localparam int HANDLE_W  = 16;
   localparam int ORDER_W   = 32;
   localparam int STATUS_W  = 2;
   // wide enough for the deepest table the block supports (1024 entries)
   localparam int IDX_MAX_W = 10;

   localparam logic OP_POST  = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_POSTED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MATCHED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   // request as broadcast to every cell
   typedef struct packed {
      logic                       op;
      logic [SOURCE_W-1:0]        source;
      logic                       wild;
      logic signed [TAG_W-1:0]    tag;
      logic                       any_tag;
      logic [HANDLE_W-1:0]        handle;
   } cmd_type;

   // best candidate so far, handed from cell to cell
   typedef struct packed {
      logic                       found;
      logic [ORDER_W-1:0]         age;
      logic [HANDLE_W-1:0]        handle;
      logic                       wild;
      logic [IDX_MAX_W-1:0]       idx;
   } token_type;

   // table update at the end of a sweep
   typedef struct packed {
      logic                       post_en;
      logic                       clear_en;
      logic [IDX_MAX_W-1:0]       idx;
   } commit_type;

endpackage

// File: sv/ptm_req_if.sv
interface ptm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic [ptm_pkg::SOURCE_W-1:0]        source_id;
   logic                                wild_source;
   logic signed [ptm_pkg::TAG_W-1:0]    tag;
   logic                                any_tag;
   logic [ptm_pkg::HANDLE_W-1:0]        handle;

   modport source (output valid, operation, source_id, wild_source, tag, any_tag, handle,
                   input ready);
   modport sink   (input valid, operation, source_id, wild_source, tag, any_tag, handle,
                   output ready);
endinterface

// File: sv/ptm_rsp_if.sv
interface ptm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ptm_pkg::STATUS_W-1:0]        status;
   logic [ptm_pkg::HANDLE_W-1:0]        matched_handle;
   logic                                matched_wild;

   modport source (output valid, status, matched_handle, matched_wild, input ready);
   modport sink   (input valid, status, matched_handle, matched_wild, output ready);
endinterface

// File: sv/ptm_cell.sv
module ptm_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptm_pkg::cmd_type              cmd,
   input  logic [ptm_pkg::ORDER_W-1:0]   post_count,
   input  ptm_pkg::commit_type           commit,
   input  ptm_pkg::token_type            prev_tok,
   output ptm_pkg::token_type            next_tok
);

   localparam logic [ptm_pkg::IDX_MAX_W-1:0] MY_IDX = ptm_pkg::IDX_MAX_W'(CELL_IDX);

   logic                                 valid_ff;
   logic                                 wild_ff;
   logic [ptm_pkg::SOURCE_W-1:0]         source_ff;
   logic signed [ptm_pkg::TAG_W-1:0]     tag_ff;
   logic                                 any_tag_ff;
   logic [ptm_pkg::HANDLE_W-1:0]         handle_ff;
   logic [ptm_pkg::ORDER_W-1:0]          order_ff;
   ptm_pkg::token_type                   tok_ff;
   ptm_pkg::token_type                   tok_in;

   logic                                 hit_src;
   logic                                 hit_tag;
   logic [ptm_pkg::ORDER_W-1:0]          age;
   logic                                 take;
   logic                                 mine;

   assign mine    = (commit.idx == MY_IDX);
   assign hit_src = wild_ff || (source_ff == cmd.source);
   // any-tag never accepts a negative fragment tag
   assign hit_tag = any_tag_ff ? !cmd.tag[ptm_pkg::TAG_W-1] : (tag_ff == cmd.tag);
   assign age     = post_count - order_ff;

   always_comb begin
      if (cmd.op == ptm_pkg::OP_MATCH) begin
         take = valid_ff && hit_src && hit_tag && (!prev_tok.found || age > prev_tok.age);
      end else begin
         take = !valid_ff && !prev_tok.found;
      end
      tok_in = prev_tok;
      if (take) begin
         tok_in.found  = 1'b1;
         tok_in.age    = age;
         tok_in.handle = handle_ff;
         tok_in.wild   = wild_ff;
         tok_in.idx    = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (commit.post_en && mine) begin
         valid_ff <= 1'b1;
      end else if (commit.clear_en && mine) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (commit.post_en && mine) begin
         wild_ff    <= cmd.wild;
         source_ff  <= cmd.source;
         tag_ff     <= cmd.tag;
         any_tag_ff <= cmd.any_tag;
         handle_ff  <= cmd.handle;
         order_ff   <= post_count;
      end
   end

   assign next_tok = tok_ff;

endmodule

// File: sv/posted_receive_tag_matcher.sv
// Table of up to TABLE_DEPTH posted receives, each a row cell holding one entry. A post
// request takes the lowest free cell, a match request removes the oldest entry whose
// source (or wild mark) and tag (or any-tag mark, non-negative tags only) accept the
// fragment. Every request is resolved by one pass of a candidate token down the row of
// cells, one cell per cycle; the length of the cell chain sets the timing. The response
// is registered when the sweep commits, and no new request is taken until the sweep of
// the previous one has committed. One response per request. A new request is taken
// while the previous response still waits; its sweep then holds at the end until the
// output register frees up. Sources are folded modulo SOURCE_COUNT on both post and
// match.
module posted_receive_tag_matcher #(
   parameter int TABLE_DEPTH  = ptm_pkg::TABLE_DEPTH_DEF,
   parameter int SOURCE_COUNT = ptm_pkg::SOURCE_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ptm_req_if.sink      req_ch,
   ptm_rsp_if.source    rsp_ch
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic                                busy_ff, busy_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ptm_pkg::ORDER_W-1:0]         counter_ff, counter_in;
   ptm_pkg::cmd_type                    cmd_ff, cmd_in;
   logic [ptm_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic [ptm_pkg::HANDLE_W-1:0]        mhandle_ff, mhandle_in;
   logic                                mwild_ff, mwild_in;

   logic                                accept;
   logic                                sweep_done;
   logic                                do_commit;
   ptm_pkg::commit_type                 commit;
   ptm_pkg::token_type                  last_tok;
   ptm_pkg::token_type                  tok [TABLE_DEPTH];

   function automatic logic [ptm_pkg::SOURCE_W-1:0] fold_source(
      input logic [ptm_pkg::SOURCE_W-1:0] s);
      logic [31:0] v;
      logic [31:0] d;
      v = 32'(s);
      // restoring reduction, one shifted modulus per step
      for (int k = ptm_pkg::SOURCE_W - 1; k >= 0; k--) begin
         d = 32'(SOURCE_COUNT) << k;
         if (v >= d) begin
            v = v - d;
         end
      end
      return v[ptm_pkg::SOURCE_W-1:0];
   endfunction

   assign accept     = req_ch.valid && !busy_ff;
   assign sweep_done = busy_ff && (count_ff == CNT_W'(TABLE_DEPTH));
   assign do_commit  = sweep_done && (!rsp_valid_ff || rsp_ch.ready);
   assign last_tok   = tok[TABLE_DEPTH-1];

   always_comb begin
      cmd_in.op      = req_ch.operation;
      cmd_in.source  = fold_source(req_ch.source_id);
      cmd_in.wild    = req_ch.wild_source;
      cmd_in.tag     = req_ch.tag;
      cmd_in.any_tag = req_ch.any_tag;
      cmd_in.handle  = req_ch.handle;

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (do_commit) begin
         busy_in = 1'b0;
      end

      count_in = count_ff;
      if (accept) begin
         count_in = '0;
      end else if (busy_ff && !sweep_done) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (do_commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      commit.post_en  = do_commit && (cmd_ff.op == ptm_pkg::OP_POST) && last_tok.found;
      commit.clear_en = do_commit && (cmd_ff.op == ptm_pkg::OP_MATCH) && last_tok.found;
      commit.idx      = last_tok.idx;

      counter_in = commit.post_en ? counter_ff + ptm_pkg::ORDER_W'(1) : counter_ff;

      mhandle_in = '0;
      mwild_in   = 1'b0;
      if (cmd_ff.op == ptm_pkg::OP_POST) begin
         status_in = last_tok.found ? ptm_pkg::ST_POSTED : ptm_pkg::ST_FULL;
      end else if (last_tok.found) begin
         status_in  = ptm_pkg::ST_MATCHED;
         mhandle_in = last_tok.handle;
         mwild_in   = last_tok.wild;
      end else begin
         status_in = ptm_pkg::ST_NO_MATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
      if (do_commit) begin
         status_ff  <= status_in;
         mhandle_ff <= mhandle_in;
         mwild_ff   <= mwild_in;
      end
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ptm_pkg::token_type prev;
      if (i == 0) begin : g_seed
         assign prev = '0;
      end else begin : g_link
         assign prev = tok[i-1];
      end
      ptm_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd_ff),
         .post_count (counter_ff),
         .commit     (commit),
         .prev_tok   (prev),
         .next_tok   (tok[i])
      );
   end

   assign req_ch.ready          = !busy_ff;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.matched_handle = mhandle_ff;
   assign rsp_ch.matched_wild   = mwild_ff;

`ifndef SYNTHESIS
   a_post_bumps_counter: assert property (@(posedge clock) disable iff (reset)
      commit.post_en |=> counter_ff == $past(counter_ff) + ptm_pkg::ORDER_W'(1))
      else $error("post counter did not advance on a stored post");

   a_match_keeps_counter: assert property (@(posedge clock) disable iff (reset)
      (do_commit && cmd_ff.op == ptm_pkg::OP_MATCH) |=> counter_ff == $past(counter_ff))
      else $error("post counter moved on a match request");

   a_rsp_from_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sweep_done))
      else $error("response raised before the sweep finished");

   a_cmd_held: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !do_commit) |=> $stable(cmd_ff))
      else $error("request changed during its sweep");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import ptm_pkg::*;

   localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
   localparam int SOURCE_COUNT = SOURCE_COUNT_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic                wild;
   } outcome_type;

   logic clock;
   logic reset;

   ptm_req_if req_ch();
   ptm_rsp_if rsp_ch();

   posted_receive_tag_matcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the receive table
   bit                      entry_live   [TABLE_DEPTH];
   bit                      entry_wild   [TABLE_DEPTH];
   logic [SOURCE_W-1:0]     entry_src    [TABLE_DEPTH];
   logic signed [TAG_W-1:0] entry_tag    [TABLE_DEPTH];
   bit                      entry_any    [TABLE_DEPTH];
   logic [HANDLE_W-1:0]     entry_handle [TABLE_DEPTH];
   logic [ORDER_W-1:0]      entry_stamp  [TABLE_DEPTH];
   logic [ORDER_W-1:0]      post_count;

   outcome_type expected_outcomes[$];
   int          error_count;
   bit          steady;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic outcome_type resolve_request(input cmd_type rq);
      outcome_type         res;
      logic [SOURCE_W-1:0] src;
      logic [ORDER_W-1:0]  age;
      logic [ORDER_W-1:0]  best_age;
      int                  slot;
      bit                  src_ok;
      bit                  tag_ok;
      res      = '{status: ST_POSTED, handle: '0, wild: 1'b0};
      src      = SOURCE_W'(rq.source % SOURCE_COUNT);
      slot     = -1;
      best_age = '0;
      if (rq.op == OP_POST) begin
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && !entry_live[i]) slot = i;
         if (slot < 0) begin
            res.status = ST_FULL;
         end else begin
            entry_live[slot]   = 1'b1;
            entry_wild[slot]   = rq.wild;
            entry_src[slot]    = src;
            entry_tag[slot]    = rq.tag;
            entry_any[slot]    = rq.any_tag;
            entry_handle[slot] = rq.handle;
            entry_stamp[slot]  = post_count;
            post_count         = post_count + 1'b1;
         end
      end else begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            src_ok = entry_wild[i] || entry_src[i] == src;
            tag_ok = entry_any[i] ? !rq.tag[TAG_W-1] : entry_tag[i] == rq.tag;
            if (entry_live[i] && src_ok && tag_ok) begin
               age = post_count - entry_stamp[i];
               // ties keep the lower slot
               if (slot < 0 || age > best_age) begin
                  slot     = i;
                  best_age = age;
               end
            end
         end
         if (slot < 0) begin
            res.status = ST_NO_MATCH;
         end else begin
            entry_live[slot] = 1'b0;
            res.status       = ST_MATCHED;
            res.handle       = entry_handle[slot];
            res.wild         = entry_wild[slot];
         end
      end
      return res;
   endfunction

   function automatic int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) n += entry_live[i];
      return n;
   endfunction

   // mostly back to back, some short gaps, a few long ones that can outlast a sweep
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [SOURCE_W-1:0] pick_source();
      if ($urandom_range(0, 3) != 0) return SOURCE_W'($urandom_range(1, 4));
      return SOURCE_W'($urandom);
   endfunction

   function automatic logic signed [TAG_W-1:0] pick_tag();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return -1;
         3: return 32'sh8000_0000;
         4: return 32'sh7FFF_FFFF;
         5, 6: return $urandom_range(2, 6);
         7: return -$signed($urandom_range(2, 4));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input cmd_type rq);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= rq.op;
      req_ch.source_id   <= rq.source;
      req_ch.wild_source <= rq.wild;
      req_ch.tag         <= rq.tag;
      req_ch.any_tag     <= rq.any_tag;
      req_ch.handle      <= rq.handle;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_outcomes.push_back(resolve_request(rq));
   endtask

   task automatic post_receive(input logic [SOURCE_W-1:0] src, input logic wild,
                               input logic signed [TAG_W-1:0] t, input logic any,
                               input logic [HANDLE_W-1:0] h);
      send_request('{op: OP_POST, source: src, wild: wild, tag: t, any_tag: any, handle: h});
   endtask

   // post-only fields carry junk on a match request
   task automatic match_fragment(input logic [SOURCE_W-1:0] src,
                                 input logic signed [TAG_W-1:0] t);
      send_request('{op: OP_MATCH, source: src, wild: 1'($urandom), tag: t,
                     any_tag: 1'($urandom), handle: HANDLE_W'($urandom)});
   endtask

   task automatic random_post();
      post_receive(pick_source(), $urandom_range(0, 3) == 0, pick_tag(),
                   $urandom_range(0, 3) == 0, HANDLE_W'($urandom));
   endtask

   // hit_pct: share of matches aimed at a live entry
   task automatic random_match(input int hit_pct);
      int                      live[$];
      int                      idx;
      logic [SOURCE_W-1:0]     src;
      logic signed [TAG_W-1:0] t;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (entry_live[i]) live.push_back(i);
      src = pick_source();
      t   = pick_tag();
      if (live.size() > 0 && $urandom_range(0, 99) < hit_pct) begin
         idx = live[$urandom_range(0, live.size() - 1)];
         if (!entry_wild[idx]) src = entry_src[idx];
         if (!entry_any[idx])
            t = entry_tag[idx];
         else if ($urandom_range(0, 3) == 0)
            t = {1'b0, 31'($urandom)};
         else
            t = $urandom_range(0, 6);
      end
      match_fragment(src, t);
   endtask

   task automatic test_directed_cases();
      match_fragment(8'd0, 0);
      post_receive(8'd0, 1'b0, 32'sh7FFF_FFFF, 1'b0, 16'hFFFF);
      post_receive(8'd255, 1'b0, 32'sh8000_0000, 1'b0, 16'h0000);
      post_receive(8'hAA, 1'b1, -1, 1'b1, 16'h1234);
      post_receive(8'd7, 1'b0, 32'sh0000_0011, 1'b1, 16'h0707);
      // any-tag wild entry must not take the negative tag
      match_fragment(8'd255, 32'sh8000_0000);
      match_fragment(8'd3, -1);
      // wild entry is older than the source-7 entry
      match_fragment(8'd7, 5);
      match_fragment(8'd7, 0);
      match_fragment(8'd0, 32'sh7FFF_FFFF);
      // age beats slot number once a low slot is reused
      post_receive(8'd9, 1'b0, 42, 1'b0, 16'd1);
      post_receive(8'd9, 1'b0, 42, 1'b0, 16'd2);
      match_fragment(8'd9, 42);
      post_receive(8'd9, 1'b0, 42, 1'b0, 16'd3);
      match_fragment(8'd9, 42);
      match_fragment(8'd9, 42);
      match_fragment(8'd9, 42);
      post_receive(8'hC8, 1'b1, 0, 1'b0, 16'h00C8);
      match_fragment(8'd200, 1);
      match_fragment(8'd17, 0);
   endtask

   task automatic test_table_full();
      int guard;
      while (occupancy() < TABLE_DEPTH) random_post();
      repeat (3) random_post();
      guard = 0;
      while (occupancy() > 0 && guard < 4 * TABLE_DEPTH) begin
         random_match(90);
         guard++;
      end
   endtask

   task automatic test_random_traffic(input int items);
      int target;
      bit grow;
      target = 0;
      for (int k = 0; k < items; k++) begin
         steady = (k % 160) >= 130;
         if (k % 40 == 0) target = $urandom_range(0, TABLE_DEPTH);
         if (occupancy() < target)
            grow = $urandom_range(0, 9) < 7;
         else
            grow = $urandom_range(0, 9) < 3;
         if (grow)
            random_post();
         else
            random_match(70);
      end
      steady = 1'b0;
   endtask

   // response side: random back-pressure
   initial begin
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         if (steady) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 6)) @(posedge clock);
            hold = pick_gap();
            if (hold > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_outcomes.size() == 0) begin
            error_count++;
            $display("%0t unexpected response: status %0d handle %h wild %b", $time,
                     rsp_ch.status, rsp_ch.matched_handle, rsp_ch.matched_wild);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_ch.status !== want.status) begin
               error_count++;
               $display("%0t status: expected %0d, got %0d", $time, want.status,
                        rsp_ch.status);
            end
            if (rsp_ch.matched_handle !== want.handle) begin
               error_count++;
               $display("%0t matched_handle: expected %h, got %h", $time, want.handle,
                        rsp_ch.matched_handle);
            end
            if (rsp_ch.matched_wild !== want.wild) begin
               error_count++;
               $display("%0t matched_wild: expected %b, got %b", $time, want.wild,
                        rsp_ch.matched_wild);
            end
         end
      end
   end

   initial begin
      error_count = 0;
      steady      = 1'b0;
      post_count  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) entry_live[i] = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_POST;
      req_ch.source_id   <= '0;
      req_ch.wild_source <= 1'b0;
      req_ch.tag         <= '0;
      req_ch.any_tag     <= 1'b0;
      req_ch.handle      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_table_full();
      test_random_traffic(700);
      req_ch.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
sv/ptm_pkg.sv
sv/ptm_req_if.sv
sv/ptm_rsp_if.sv
sv/ptm_cell.sv
sv/posted_receive_tag_matcher.sv
tb/sv/tb.sv
